@@ sv/adccal_pkg.sv @@
// types and constants for the adc channel calibration block
// used by adccal_cfg, adccal_div and adc_channel_calibration; no dependencies
package adccal_pkg;

  // constants: the ratio offset and reference limits are Q16.16, the gain ones plain integers
  localparam int unsigned    DefaultGain  = 10000;    // gain of 100.00 in hundredths
  localparam int unsigned    GainDivisor  = 100;
  localparam int unsigned    GainRound    = 50;
  localparam int unsigned    RatioMul     = 250;
  localparam logic [31:0]    RatioOffset  = 32'd1638400;  // 25.0
  localparam logic [31:0]    RefMinOk     = 32'd6554;     // just above 0.1
  localparam logic [31:0]    RefFallback  = 32'd327680;   // 5.0

  // divider geometry
  localparam int unsigned    DivNumW   = 44;
  localparam int unsigned    DivDenW   = 32;
  localparam int unsigned    DivCntW   = $clog2(DivNumW + 1);

  // input and output words
  typedef struct packed {
    logic [7:0]  channel;
    logic [15:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         result_channel;
    logic signed [31:0] cooked_value;
    logic               channel_enabled;
  } out_item_t;

  // register indexes
  typedef enum logic [2:0] {
    CfgTypeMap    = 3'd0,
    CfgEnableMask = 3'd1,
    CfgGainACh    = 3'd2,
    CfgGainAHund  = 3'd3,
    CfgGainBCh    = 3'd4,
    CfgGainBHund  = 3'd5
  } cfg_idx_e;

  // per channel treatment
  typedef enum logic [1:0] {
    TypePlain = 2'd0,
    TypeGain  = 2'd1,
    TypeRatio = 2'd2,
    TypeRsvd  = 2'd3
  } cal_type_e;

  typedef struct packed {
    logic [31:0] type_map;
    logic [15:0] enable_mask;
    logic [4:0]  gain_a_channel;
    logic [15:0] gain_a_hundredths;
    logic [4:0]  gain_b_channel;
    logic [15:0] gain_b_hundredths;
  } cfg_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quotient;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [1:0] {
    StIdle = 2'd0,
    StMul  = 2'd1,
    StDiv  = 2'd2,
    StOut  = 2'd3
  } state_e;

endpackage

@@ sv/adccal_cfg.sv @@
// configuration registers of the adc channel calibration block
// depends on adccal_pkg for the register index codes and cfg_t
module adccal_cfg import adccal_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // writes are always accepted, ready is tied high
  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgTypeMap:    cfg_d.type_map          = cfg_data_i;
        CfgEnableMask: cfg_d.enable_mask       = cfg_data_i[15:0];
        CfgGainACh:    cfg_d.gain_a_channel    = cfg_data_i[4:0];
        CfgGainAHund:  cfg_d.gain_a_hundredths = cfg_data_i[15:0];
        CfgGainBCh:    cfg_d.gain_b_channel    = cfg_data_i[4:0];
        CfgGainBHund:  cfg_d.gain_b_hundredths = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_map          <= 32'h0555_5560;
      cfg_q.enable_mask       <= 16'd1;
      cfg_q.gain_a_channel    <= 5'd7;
      cfg_q.gain_a_hundredths <= 16'd25238;
      cfg_q.gain_b_channel    <= 5'd8;
      cfg_q.gain_b_hundredths <= 16'd10015;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/adccal_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on adccal_pkg for div_req_t, div_rsp_t and the divider widths
module adccal_div import adccal_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;

  // one shift and trial subtract step
  assign trial = {rem_q, quo_q[DivNumW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = DivCntW'(DivNumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // divisor stays below 2^31, so a kept remainder fits
      if (!diff[DivDenW]) begin
        rem_d = diff[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivDenW-1:0];
        quo_d = {quo_q[DivNumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ sv/adc_channel_calibration.sv @@
// adc channel calibration top level: sequencer, multiplier and output register
// depends on adccal_pkg, adccal_cfg and adccal_div
//
//   port group   direction  handshake              carries
//   in_*         in         in_valid_i/in_stall_o  in_item_t (channel, raw_sample)
//   out_*        out        out_valid_o/out_stall_i out_item_t (channel, value, enable)
//   cfg_*        in         cfg_valid_i/cfg_ready_o register index and 32-bit data
//
// plain volts words go from accept straight to the output state, dropped channels
// are only accepted; gain and ratiometric words pass through accept, one multiply,
// 44 divider steps, taking the quotient and the output state, paced by the shared
// one-bit-per-cycle divider.
// after reset the registers hold their defaults and the reference is zero.
// a stalled output holds its word; the next input word is taken meanwhile,
// and the sequencer waits in its output state only while that word is held.
module adc_channel_calibration import adccal_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [7:0] ChanLimit = 8'(CHANNELS);

  cfg_t      cfg;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  state_e    state_q, state_d;
  logic [3:0]  ch_q, ch_d;
  logic [19:0] volts_q, volts_d;
  cal_type_e   type_q, type_d;
  logic [15:0] gain_q, gain_d;
  logic [31:0] res_q, res_d;
  logic [31:0] ref_q, ref_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        in_take;
  logic        out_free;
  logic [3:0]  in_ch;
  logic [15:0] mul_op;
  logic [35:0] prod;
  logic [31:0] ratio_ref;
  logic [15:0] mask_eff;

  adccal_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  adccal_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall_o = (state_q != StIdle);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_ch      = in_data_i.channel[3:0];

  // shared multiplier: gain for linear channels, 250 for ratiometric
  assign mul_op = (type_q == TypeRatio) ? 16'(RatioMul) : gain_q;
  assign prod   = 36'(volts_q) * 36'(mul_op);

  // reference below 0.1 (or negative) falls back to 5.0
  assign ratio_ref = ($signed(ref_q) >= $signed(RefMinOk)) ? ref_q : RefFallback;

  // empty mask leaves only channel 0 enabled
  assign mask_eff = (cfg.enable_mask == '0) ? 16'd1 : cfg.enable_mask;

  // sequencer and datapath next state
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    volts_d     = volts_q;
    type_d      = type_q;
    gain_d      = gain_q;
    res_d       = res_q;
    ref_d       = ref_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_req     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_take && (in_data_i.channel < ChanLimit)) begin
          ch_d    = in_ch;
          volts_d = {1'b0, in_data_i.raw_sample, 3'b000}
                  + {3'b000, in_data_i.raw_sample, 1'b0};
          type_d  = cal_type_e'(cfg.type_map[{in_ch, 1'b0} +: 2]);
          if (cfg.gain_a_channel == {1'b0, in_ch}) begin
            gain_d = cfg.gain_a_hundredths;
          end else if (cfg.gain_b_channel == {1'b0, in_ch}) begin
            gain_d = cfg.gain_b_hundredths;
          end else begin
            gain_d = 16'(DefaultGain);
          end
          case (cal_type_e'(cfg.type_map[{in_ch, 1'b0} +: 2])) inside
            TypeGain, TypeRatio: state_d = StMul;
            default: begin
              res_d   = {12'h000, volts_d};
              state_d = StOut;
            end
          endcase
        end
      end
      StMul: begin
        // product goes straight into the divider registers
        div_req.start = 1'b1;
        if (type_q == TypeRatio) begin
          div_req.dividend = {prod[27:0], 16'h0000};
          div_req.divisor  = ratio_ref;
        end else begin
          div_req.dividend = {8'h00, prod + 36'(GainRound)};
          div_req.divisor  = 32'(GainDivisor);
        end
        state_d = StDiv;
      end
      StDiv: begin
        // quotients stay below 2^31, so no clamp is reached
        if (div_rsp.done) begin
          if (type_q == TypeRatio) begin
            res_d = div_rsp.quotient[31:0] - RatioOffset;
          end else begin
            res_d = div_rsp.quotient[31:0];
          end
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_d.result_channel  = ch_q;
          out_d.cooked_value    = $signed(res_q);
          out_d.channel_enabled = mask_eff[ch_q];
          out_valid_d           = 1'b1;
          if (ch_q == 4'd0) begin
            ref_d = res_q;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      ref_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ref_q       <= ref_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    volts_q <= volts_d;
    type_q  <= type_d;
    gain_q  <= gain_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/adc_channel_calibration_tb.sv @@
// self-checking testbench for adc_channel_calibration: directed and random sample words
// depends on adccal_pkg and the adc_channel_calibration rtl; predicts every result in-house
module adc_channel_calibration_tb;
  import adccal_pkg::*;

  localparam int          CycleLimit  = 400000;
  localparam int          SettleWait  = 60;      // longer than the whole divide path
  localparam int          RandomWords = 100;     // per register setting
  localparam int          Settings    = 7;
  localparam logic [2:0]  CfgBeyondLo = 3'd6;    // indexes with no register behind them
  localparam logic [2:0]  CfgBeyondHi = 3'd7;

  // expected calibrated words, register shadow and channel 0 reference
  class calib_tracker;
    cfg_t      cfg;
    int        ref_volts;
    out_item_t cooked_due[$];
    int        errors;

    function new();
      cfg.type_map          = 32'h0555_5560;
      cfg.enable_mask       = 16'd1;
      cfg.gain_a_channel    = 5'd7;
      cfg.gain_a_hundredths = 16'd25238;
      cfg.gain_b_channel    = 5'd8;
      cfg.gain_b_hundredths = 16'd10015;
      ref_volts             = 0;
      errors                = 0;
    endfunction

    // register write as the block sees it, masked to each width
    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CfgTypeMap:    cfg.type_map          = d;
        CfgEnableMask: cfg.enable_mask       = d[15:0];
        CfgGainACh:    cfg.gain_a_channel    = d[4:0];
        CfgGainAHund:  cfg.gain_a_hundredths = d[15:0];
        CfgGainBCh:    cfg.gain_b_channel    = d[4:0];
        CfgGainBHund:  cfg.gain_b_hundredths = d[15:0];
        default: ;
      endcase
    endfunction

    // work out the cooked value of one accepted sample word
    function void note_sample(in_item_t w);
      out_item_t  e;
      logic [3:0] ch;
      logic [15:0] mask;
      cal_type_e  kind;
      longint     volts, gain, denom, res;
      int         cooked;
      if (w.channel >= 8'd16) return;
      ch = w.channel[3:0];
      volts = longint'(w.raw_sample) * 10;
      kind = cal_type_e'(cfg.type_map[2*ch +: 2]);
      case (kind)
        TypeGain: begin
          gain = longint'(DefaultGain);
          if (cfg.gain_a_channel == {1'b0, ch}) gain = longint'(cfg.gain_a_hundredths);
          else if (cfg.gain_b_channel == {1'b0, ch}) gain = longint'(cfg.gain_b_hundredths);
          res = (volts * gain + longint'(GainRound)) / longint'(GainDivisor);
        end
        TypeRatio: begin
          // tiny or negative reference falls back to 5.0
          denom = (ref_volts >= int'(RefMinOk)) ? longint'(ref_volts) : longint'(RefFallback);
          res = volts * longint'(RatioMul) * 64'sd65536 / denom - longint'(RatioOffset);
        end
        default: res = volts;
      endcase
      if (res > 64'sd2147483647) cooked = 32'sh7FFF_FFFF;
      else if (res < -64'sd2147483648) cooked = 32'sh8000_0000;
      else cooked = int'(res);
      if (ch == 4'd0) ref_volts = cooked;
      mask = (cfg.enable_mask == 16'd0) ? 16'd1 : cfg.enable_mask;
      e.result_channel  = ch;
      e.cooked_value    = cooked;
      e.channel_enabled = mask[ch];
      cooked_due.push_back(e);
    endfunction

    // compare one accepted result word against the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      if (cooked_due.size() == 0) begin
        $error("unexpected result word: channel %0d value %0d", got.result_channel,
               got.cooked_value);
        errors++;
        return;
      end
      e = cooked_due.pop_front();
      if (got.result_channel !== e.result_channel) begin
        $error("result_channel: expected %0d, got %0d", e.result_channel, got.result_channel);
        errors++;
      end
      if (got.cooked_value !== e.cooked_value) begin
        $error("cooked_value: expected %0d, got %0d", e.cooked_value, got.cooked_value);
        errors++;
      end
      if (got.channel_enabled !== e.channel_enabled) begin
        $error("channel_enabled: expected %0d, got %0d", e.channel_enabled,
               got.channel_enabled);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  calib_tracker sb;
  bit           quiet;
  int           cycle_count;

  adc_channel_calibration dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("adc_channel_calibration regression: fail");
      $finish;
    end
  end

  // result words accepted at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver stalls in bursts
  always begin
    @(negedge clk_i);
    if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // one sample word, entered just after a falling edge and held until the block takes it
  task automatic send_sample(input logic [7:0] ch, input logic [15:0] raw);
    in_item_t w;
    w.channel    = ch;
    w.raw_sample = raw;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(w);
    @(negedge clk_i);
  endtask

  // one register write; the caller lowers valid after the last one
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
  endtask

  // drain: every result in, then room for a dropped word still in flight
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.cooked_due.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_random_samples(input int n);
    logic [7:0]  ch;
    logic [15:0] raw;
    int          sel;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) ch = 8'($urandom_range(16, 255));
      else if (sel <= 2) ch = 8'd0;
      else ch = 8'($urandom_range(1, 15));
      case ($urandom_range(0, 7))
        0: raw = 16'h0000;
        1: raw = 16'hFFFF;
        2: raw = 16'($urandom_range(600, 700));   // around the reference threshold
        default: raw = 16'($urandom);
      endcase
      send_sample(ch, raw);
    end
  endtask

  // main sequence
  initial begin
    logic [31:0] tmap;
    logic [15:0] ena, hund_a, hund_b;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgTypeMap;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    cycle_count = 0;
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // defaults: fallback reference, gain overrides, dropped channels, threshold
    send_sample(8'd0, 16'd0);
    send_sample(8'd2, 16'hFFFF);
    send_sample(8'd2, 16'd0);
    send_sample(8'd7, 16'hFFFF);
    send_sample(8'd8, 16'hFFFF);
    send_sample(8'd3, 16'd1);
    send_sample(8'd3, 16'hFFFF);
    send_sample(8'd15, 16'hFFFF);
    send_sample(8'd14, 16'd0);
    send_sample(8'd16, 16'd1234);
    send_sample(8'd255, 16'hFFFF);
    send_sample(8'd128, 16'd0);
    send_sample(8'd0, 16'hFFFF);
    send_sample(8'd2, 16'd32768);
    send_sample(8'd0, 16'd655);
    send_sample(8'd2, 16'd100);
    send_sample(8'd0, 16'd656);
    wait_idle();

    // ratiometric channel 0, reserved type, empty mask, equal gain channels
    cfg_write(CfgTypeMap, 32'h6F9C_251E);
    cfg_write(CfgEnableMask, 32'hABCD_0000);
    cfg_write(CfgGainACh, 32'd4);
    cfg_write(CfgGainBCh, 32'd4);
    cfg_write(CfgGainAHund, 32'h0000_FFFF);
    cfg_write(CfgGainBHund, 32'h0000_0000);
    cfg_valid_i <= 1'b0;
    send_sample(8'd0, 16'd1000);
    send_sample(8'd0, 16'd1000);
    send_sample(8'd1, 16'hFFFF);
    send_sample(8'd4, 16'hFFFF);
    send_sample(8'd6, 16'hFFFF);
    wait_idle();

    // no gain channel, override on a plain channel, writes to unused indexes
    cfg_write(CfgGainACh, 32'hFFFF_FFF0);
    cfg_write(CfgGainBCh, 32'd7);
    cfg_write(CfgBeyondLo, 32'hFFFF_FFFF);
    cfg_write(CfgBeyondHi, 32'h1234_5678);
    cfg_valid_i <= 1'b0;
    send_sample(8'd4, 16'd777);
    send_sample(8'd7, 16'hFFFF);
    send_sample(8'd0, 16'd50000);
    wait_idle();

    // random words under a run of register settings, the extremes first
    for (int p = 0; p < Settings; p++) begin
      case (p)
        0: begin tmap = 32'h0000_0000; ena = 16'hFFFF; hund_a = 16'd0;     hund_b = 16'd0;     end
        1: begin tmap = 32'hFFFF_FFFF; ena = 16'h0000; hund_a = 16'hFFFF; hund_b = 16'hFFFF; end
        2: begin tmap = 32'hAAAA_AAAA; ena = 16'($urandom); hund_a = 16'($urandom);
                 hund_b = 16'($urandom); end
        3: begin tmap = 32'h5555_5555; ena = 16'($urandom); hund_a = 16'hFFFF;
                 hund_b = 16'd0; end
        default: begin tmap = $urandom; ena = 16'($urandom); hund_a = 16'($urandom);
                 hund_b = 16'($urandom); end
      endcase
      cfg_write(CfgTypeMap, tmap);
      cfg_write(CfgEnableMask, {16'($urandom), ena});
      cfg_write(CfgGainACh, $urandom);
      cfg_write(CfgGainAHund, {16'($urandom), hund_a});
      cfg_write(CfgGainBCh, $urandom);
      cfg_write(CfgGainBHund, {16'($urandom), hund_b});
      cfg_valid_i <= 1'b0;
      // last setting runs at full rate on both sides
      if (p == Settings - 1) quiet = 1'b1;
      send_random_samples(RandomWords);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("adc_channel_calibration regression: pass");
    end else begin
      $display("adc_channel_calibration regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/adccal_pkg.sv
sv/adccal_cfg.sv
sv/adccal_div.sv
sv/adc_channel_calibration.sv
tb/adc_channel_calibration_tb.sv
